### rtl/core/xydpr_pkg.sv
// Package for the XY delay/feedback parameter ramp.
// Holds the preset ROM, exponent coefficients and item field types.
// No dependencies.
package xydpr_pkg;

	typedef struct packed {
		logic        command;
		logic [16:0] x_pos;
		logic [16:0] y_pos;
	} in_item_t;

	typedef struct packed {
		logic [14:0] delay_time;
		logic [14:0] feedback_amount;
		logic        ramping;
	} out_item_t;

	localparam logic [1:0] CFG_PRESET    = 2'd0;
	localparam logic [1:0] CFG_SMOOTHING = 2'd1;
	localparam logic [1:0] CFG_STEPS     = 2'd2;

	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Center mapping of row zero, x = y = 0.5
	localparam logic [14:0] RESET_DELAY = 15'd3578;
	localparam logic [14:0] RESET_FB    = 15'd11469;

	function automatic logic [14:0] row_dmin(input logic [2:0] r);
		case (r)
			3'd0: row_dmin = 15'd800;
			3'd1: row_dmin = 15'd320;
			3'd2: row_dmin = 15'd1600;
			3'd3: row_dmin = 15'd3200;
			3'd4: row_dmin = 15'd960;
			3'd5: row_dmin = 15'd4800;
			3'd6: row_dmin = 15'd1920;
			default: row_dmin = 15'd160;
		endcase
	endfunction

	function automatic logic [14:0] row_dmax(input logic [2:0] r);
		case (r)
			3'd0: row_dmax = 15'd16000;
			3'd1: row_dmax = 15'd3200;
			3'd2: row_dmax = 15'd12800;
			3'd3: row_dmax = 15'd32000;
			3'd4: row_dmax = 15'd16000;
			3'd5: row_dmax = 15'd32000;
			3'd6: row_dmax = 15'd9600;
			default: row_dmax = 15'd32000;
		endcase
	endfunction

	function automatic logic [18:0] row_log2(input logic [2:0] r);
		case (r)
			3'd0: row_log2 = 19'd283242;
			3'd1: row_log2 = 19'd217706;
			3'd2: row_log2 = 19'd196608;
			3'd3: row_log2 = 19'd217706;
			3'd4: row_log2 = 19'd266004;
			3'd5: row_log2 = 19'd179370;
			3'd6: row_log2 = 19'd152170;
			default: row_log2 = 19'd500948;
		endcase
	endfunction

	function automatic logic [14:0] row_fmin(input logic [2:0] r);
		case (r)
			3'd2: row_fmin = 15'd3277;
			3'd3: row_fmin = 15'd6554;
			3'd5: row_fmin = 15'd9830;
			3'd6: row_fmin = 15'd3277;
			default: row_fmin = 15'd0;
		endcase
	endfunction

	function automatic logic [14:0] row_fmax(input logic [2:0] r);
		case (r)
			3'd0: row_fmax = 15'd22938;
			3'd1: row_fmax = 15'd9830;
			3'd2: row_fmax = 15'd19661;
			3'd3: row_fmax = 15'd26214;
			3'd4: row_fmax = 15'd16384;
			3'd5: row_fmax = 15'd29491;
			3'd6: row_fmax = 15'd22938;
			default: row_fmax = 15'd31130;
		endcase
	endfunction

	// ln2^k/k! in Q30, k = 6 down to 1; index 6 is the constant one
	function automatic logic [30:0] exp_coef(input logic [2:0] k);
		case (k)
			3'd0: exp_coef = 31'd165394;
			3'd1: exp_coef = 31'd1431680;
			3'd2: exp_coef = 31'd10327388;
			3'd3: exp_coef = 31'd59597083;
			3'd4: exp_coef = 31'd257941247;
			3'd5: exp_coef = 31'd744261118;
			default: exp_coef = 31'd1073741824;
		endcase
	endfunction

endpackage

### rtl/core/xydpr_stream_if.sv
// Valid/ready channel interface carrying one payload item.
// Payload type is a parameter; used with xydpr_pkg item types.
interface xydpr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/xy_delay_parameter_ramp.sv
// XY delay/feedback parameter ramp, top level.
// Depends on xydpr_pkg and xydpr_stream_if.
//
// Usage:
//   in_ch  carries items {command, x_pos, y_pos}; command 0 sets a position,
//          command 1 is a tick that advances a running ramp by one step.
//   out_ch returns one item {delay_time, feedback_amount, ramping} per input.
//   cfg_we/cfg_index/cfg_data write preset_select (0), smoothing_on (1) and
//   ramp_steps (2); write only while the block is idle.
// Timing:
//   A tick passes the TICK and OUT states before its result is offered. A
//   set position that jumps passes one exponent step, six Horner steps on
//   the one shared multiplier, one scale step and one feedback step. A set
//   position that starts a ramp adds two restoring divisions of AW quotient
//   bits each (AW = FRAC_BITS+17, one quotient bit per cycle). After the
//   result is taken the block returns to idle before the next accept, so it
//   never takes a new item before the last result is taken.
//   in_ch.ready is low while an item is in work and while its result waits.
// Reset:
//   Registers go to preset 0, smoothing on, 4800 steps; both values sit at the
//   center mapping of preset 0 with no ramp running. Results are held in the
//   output register for as long as the receiver stalls.
module xy_delay_parameter_ramp #(
	parameter int FRAC_BITS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	xydpr_stream_if.sink        in_ch,
	xydpr_stream_if.source      out_ch,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int AW = 15 + FRAC_BITS + 2;   // accumulator incl. sign
	localparam int CW = COUNT_BITS;
	localparam int CNW = $clog2(AW + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EXPO = 4'd1;
	localparam logic [3:0] ST_HORN = 4'd2;
	localparam logic [3:0] ST_SCAL = 4'd3;
	localparam logic [3:0] ST_GOAL = 4'd4;
	localparam logic [3:0] ST_DIVS = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_TICK = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;
	localparam logic [3:0] ST_HOLD = 4'd9;

	logic [3:0]  state_q;
	logic [2:0]  preset_q;
	logic        smooth_q;
	logic [15:0] steps_cfg_q;

	logic signed [AW-1:0] dnow_q, fnow_q, dinc_q, finc_q;
	logic [14:0] dgoal_q, fgoal_q;
	logic [CW-1:0] left_q;

	logic [16:0] x_q, y_q;
	logic [2:0]  k_q;
	logic [18:0] e_q;
	logic [30:0] p_q;
	logic        which_q;
	logic [AW-1:0] rem_q, quo_q, dvd_q;
	logic        neg_q;
	logic [CNW-1:0] bit_q;
	logic [CW-1:0] steps_q;
	xydpr_pkg::out_item_t res_q;

	// Shared multiplier operands
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_EXPO: begin
				mul_a = {15'd0, x_q};
				mul_b = {13'd0, xydpr_pkg::row_log2(preset_q)};
			end
			ST_HORN: begin
				mul_a = {1'b0, p_q};
				mul_b = {16'd0, e_q[15:0]};
			end
			ST_SCAL: begin
				mul_a = {17'd0, xydpr_pkg::row_dmin(preset_q)};
				mul_b = {1'b0, p_q};
			end
			ST_GOAL: begin
				mul_a = {17'd0, xydpr_pkg::row_fmax(preset_q) - xydpr_pkg::row_fmin(preset_q)};
				mul_b = {15'd0, y_q};
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// Delay from scaled product, clamped to the row bounds; feedback mapped from the row minimum
	logic [52:0] dsh;
	logic [22:0] draw;
	logic [14:0] dclamp, fmap;
	always_comb begin
		dsh  = 53'(mul_p[45:0]) << e_q[18:16];
		draw = 23'((dsh + 53'(1 << 29)) >> 30);
		if (draw < 23'(xydpr_pkg::row_dmin(preset_q)))
			dclamp = xydpr_pkg::row_dmin(preset_q);
		else if (draw > 23'(xydpr_pkg::row_dmax(preset_q)))
			dclamp = xydpr_pkg::row_dmax(preset_q);
		else
			dclamp = draw[14:0];
		fmap = xydpr_pkg::row_fmin(preset_q) + 15'((mul_p[31:0] + 32'd32768) >> 16);
	end

	// Differences to divide and divider trial step
	logic signed [AW-1:0] ddiff, fdiff, sdiff;
	logic [AW-1:0] adiff, trial;
	logic [AW:0] sub;
	always_comb begin
		ddiff = $signed({2'b0, dgoal_q, FRAC_BITS'(0)}) - dnow_q;
		fdiff = $signed({2'b0, fgoal_q, FRAC_BITS'(0)}) - fnow_q;
		sdiff = which_q ? fdiff : ddiff;
		adiff = sdiff[AW-1] ? AW'(-sdiff) : AW'(sdiff);
		trial = {rem_q[AW-2:0], dvd_q[AW-1]};
		sub   = {1'b0, trial} - {{(AW+1-CW){1'b0}}, steps_q};
	end

	function automatic logic [14:0] outv(input logic signed [AW-1:0] v);
		logic [AW-1:0] r;
		r = (AW'(v) + AW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		outv = (r > AW'(32767)) ? 15'd32767 : r[14:0];
	endfunction

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_HOLD);
	assign out_ch.data  = res_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q    <= '0;
			smooth_q    <= 1'b1;
			steps_cfg_q <= 16'd4800;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xydpr_pkg::CFG_PRESET:    preset_q    <= cfg_data[2:0];
				xydpr_pkg::CFG_SMOOTHING: smooth_q    <= cfg_data[0];
				xydpr_pkg::CFG_STEPS:     steps_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dgoal_q <= xydpr_pkg::RESET_DELAY;
			fgoal_q <= xydpr_pkg::RESET_FB;
			dnow_q  <= $signed({2'b0, xydpr_pkg::RESET_DELAY, FRAC_BITS'(0)});
			fnow_q  <= $signed({2'b0, xydpr_pkg::RESET_FB, FRAC_BITS'(0)});
			dinc_q  <= '0;
			finc_q  <= '0;
			left_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			steps_q <= '0;
			e_q     <= '0;
			p_q     <= '0;
			k_q     <= '0;
			which_q <= 1'b0;
			dvd_q   <= '0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
			quo_q   <= '0;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						x_q <= (in_ch.data.x_pos > 17'd65536) ? 17'd65536 : in_ch.data.x_pos;
						y_q <= (in_ch.data.y_pos > 17'd65536) ? 17'd65536 : in_ch.data.y_pos;
						steps_q <= CW'(steps_cfg_q);
						state_q <= (in_ch.data.command == xydpr_pkg::CMD_TICK) ? ST_TICK : ST_EXPO;
					end
				end
				ST_EXPO: begin
					e_q <= 19'((mul_p[35:0] + 36'd32768) >> 16);
					p_q <= xydpr_pkg::exp_coef(3'd0);
					k_q <= 3'd1;
					state_q <= ST_HORN;
				end
				ST_HORN: begin
					p_q <= xydpr_pkg::exp_coef(k_q) + 31'(mul_p[46:16]);
					k_q <= k_q + 3'd1;
					if (k_q == 3'd6) state_q <= ST_SCAL;
				end
				ST_SCAL: begin
					dgoal_q <= dclamp;
					state_q <= ST_GOAL;
				end
				ST_GOAL: begin
					fgoal_q <= fmap;
					if (smooth_q && steps_q != '0) begin
						which_q <= 1'b0;
						state_q <= ST_DIVS;
					end else begin
						dnow_q  <= $signed({2'b0, dgoal_q, FRAC_BITS'(0)});
						fnow_q  <= $signed({2'b0, fmap, FRAC_BITS'(0)});
						dinc_q  <= '0;
						finc_q  <= '0;
						left_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_DIVS: begin
					dvd_q <= adiff;
					neg_q <= sdiff[AW-1];
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= CNW'(AW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (bit_q != '0) begin
						rem_q <= sub[AW] ? trial : sub[AW-1:0];
						quo_q <= {quo_q[AW-2:0], ~sub[AW]};
						dvd_q <= {dvd_q[AW-2:0], 1'b0};
						bit_q <= bit_q - CNW'(1);
					end else if (!which_q) begin
						dinc_q  <= neg_q ? -$signed(quo_q) : $signed(quo_q);
						which_q <= 1'b1;
						state_q <= ST_DIVS;
					end else begin
						finc_q  <= neg_q ? -$signed(quo_q) : $signed(quo_q);
						left_q  <= steps_q;
						state_q <= ST_OUT;
					end
				end
				ST_TICK: begin
					if (smooth_q && left_q != '0) begin
						if (left_q == CW'(1)) begin
							dnow_q <= $signed({2'b0, dgoal_q, FRAC_BITS'(0)});
							fnow_q <= $signed({2'b0, fgoal_q, FRAC_BITS'(0)});
							dinc_q <= '0;
							finc_q <= '0;
						end else begin
							dnow_q <= dnow_q + dinc_q;
							fnow_q <= fnow_q + finc_q;
						end
						left_q <= left_q - CW'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the result item
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			res_q.delay_time      <= outv(dnow_q);
			res_q.feedback_amount <= outv(fnow_q);
			res_q.ramping         <= (left_q != '0);
		end
	end

endmodule

### tb/testbench.sv
// Self-checking testbench for the XY delay/feedback parameter ramp.
// Depends on xydpr_pkg, xydpr_stream_if and xy_delay_parameter_ramp.
// Directed table first, then short ramp and register cases, then random phases under varied register settings.
module testbench;

	// Register index with no register behind it
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	xydpr_stream_if #(.T(xydpr_pkg::in_item_t)) in_ch ();
	xydpr_stream_if #(.T(xydpr_pkg::out_item_t)) out_ch ();

	xy_delay_parameter_ramp DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Register copies and ramp state of the predictor
	logic [2:0] preset_q;
	logic smooth_q;
	logic [15:0] steps_q;
	longint dly_acc, fb_acc, dly_inc, fb_inc;
	logic [14:0] dly_goal, fb_goal;
	int ramp_left;

	xydpr_pkg::out_item_t pending_results[$];
	int n_fail = 0;
	bit calm = 0;
	bit hold_req = 0;

	typedef struct {
		logic cmd;
		logic [16:0] x;
		logic [16:0] y;
		bit known;
		xydpr_pkg::out_item_t res;
	} stim_row_t;

	stim_row_t dir_rows[$];

	function automatic logic [14:0] delay_of(logic [2:0] r, logic [16:0] x);
		longint unsigned e, f, p, d;
		int ip;
		e = (longint'(x) * longint'(xydpr_pkg::row_log2(r)) + 32768) >> 16;
		ip = int'((e >> 16) & 7);
		f = e & 64'hFFFF;
		p = xydpr_pkg::exp_coef(3'd0);
		for (int k = 1; k < 6; k++)
			p = xydpr_pkg::exp_coef(3'(k)) + ((p * f) >> 16);
		p = (64'd1 << 30) + ((p * f) >> 16);
		d = (((longint'(xydpr_pkg::row_dmin(r)) * p) << ip) + (64'd1 << 29)) >> 30;
		if (d < xydpr_pkg::row_dmin(r)) d = xydpr_pkg::row_dmin(r);
		if (d > xydpr_pkg::row_dmax(r)) d = xydpr_pkg::row_dmax(r);
		return 15'(d);
	endfunction

	function automatic logic [14:0] feedback_of(logic [2:0] r, logic [16:0] y);
		longint span;
		span = longint'(xydpr_pkg::row_fmax(r)) - longint'(xydpr_pkg::row_fmin(r));
		return 15'(longint'(xydpr_pkg::row_fmin(r)) + ((span * longint'(y) + 32768) >>> 16));
	endfunction

	function automatic logic [14:0] round_acc(longint a);
		longint v;
		v = (a + 32768) >>> 16;
		return (v > 32767) ? 15'd32767 : 15'(v);
	endfunction

	function automatic void snap_to_goals();
		dly_acc = longint'(dly_goal) << 16;
		fb_acc = longint'(fb_goal) << 16;
		dly_inc = 0;
		fb_inc = 0;
		ramp_left = 0;
	endfunction

	// Advance the ramp state for one accepted item and return its result
	function automatic xydpr_pkg::out_item_t ramp_result(xydpr_pkg::in_item_t it);
		xydpr_pkg::out_item_t o;
		logic [16:0] x, y;
		longint n;
		x = (it.x_pos > 17'd65536) ? 17'd65536 : it.x_pos;
		y = (it.y_pos > 17'd65536) ? 17'd65536 : it.y_pos;
		if (it.command == xydpr_pkg::CMD_SET) begin
			n = longint'(steps_q);
			dly_goal = delay_of(preset_q, x);
			fb_goal = feedback_of(preset_q, y);
			if (smooth_q && n != 0) begin
				dly_inc = ((longint'(dly_goal) << 16) - dly_acc) / n;
				fb_inc = ((longint'(fb_goal) << 16) - fb_acc) / n;
				ramp_left = int'(n);
			end else begin
				snap_to_goals();
			end
		end else if (smooth_q && ramp_left != 0) begin
			dly_acc += dly_inc;
			fb_acc += fb_inc;
			ramp_left--;
			if (ramp_left == 0) snap_to_goals();
		end
		o.delay_time = round_acc(dly_acc);
		o.feedback_amount = round_acc(fb_acc);
		o.ramping = (ramp_left != 0);
		return o;
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#30000000;
		$display("Test completed with failures");
		$finish;
	end

	// Check each returned item against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation waiting");
				n_fail++;
			end else begin
				xydpr_pkg::out_item_t e;
				e = pending_results.pop_front();
				if (out_ch.data.delay_time !== e.delay_time) begin
					$error("delay_time expected %0d got %0d", e.delay_time,
						out_ch.data.delay_time);
					n_fail++;
				end
				if (out_ch.data.feedback_amount !== e.feedback_amount) begin
					$error("feedback_amount expected %0d got %0d", e.feedback_amount,
						out_ch.data.feedback_amount);
					n_fail++;
				end
				if (out_ch.data.ramping !== e.ramping) begin
					$error("ramping expected %0d got %0d", e.ramping, out_ch.data.ramping);
					n_fail++;
				end
			end
		end
	end

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int hold_cnt;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_cnt = 0;
				out_ch.ready <= 0;
				while (hold_cnt < 400) begin
					@(posedge clk);
					hold_cnt++;
				end
				hold_req = 0;
			end else begin
				out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
			end
		end
	end

	// Offer one item, hold it until accepted, then record its result
	task automatic send_item(xydpr_pkg::in_item_t it, bit known, xydpr_pkg::out_item_t res);
		xydpr_pkg::out_item_t e;
		while (!calm && $urandom_range(99) < 9) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		e = ramp_result(it);
		if (known && e !== res) begin
			$error("predictor disagrees with directed row");
			n_fail++;
		end
		pending_results.push_back(known ? res : e);
	endtask

	task automatic drain();
		int guard;
		in_ch.valid <= 0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	// Write one register, then drop the enable and update the predictor's copy
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		case (idx)
			xydpr_pkg::CFG_PRESET: preset_q = val[2:0];
			xydpr_pkg::CFG_SMOOTHING: smooth_q = val[0];
			xydpr_pkg::CFG_STEPS: steps_q = val;
			default: ;
		endcase
	endtask

	function automatic xydpr_pkg::in_item_t random_item(int tick_pct);
		xydpr_pkg::in_item_t it;
		it.command = ($urandom_range(99) < tick_pct) ? xydpr_pkg::CMD_TICK : xydpr_pkg::CMD_SET;
		it.x_pos = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
		it.y_pos = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
		return it;
	endfunction

	task automatic add_row(logic cmd, logic [16:0] x, logic [16:0] y);
		stim_row_t r;
		r.cmd = cmd;
		r.x = x;
		r.y = y;
		r.known = 0;
		r.res = '0;
		dir_rows.push_back(r);
	endtask

	initial begin
		stim_row_t r;
		xydpr_pkg::in_item_t it;
		int sent, phase_items;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = xydpr_pkg::CFG_PRESET;
		cfg_data = '0;
		in_ch.valid = 0;
		in_ch.data = '0;
		preset_q = 3'd0;
		smooth_q = 1;
		steps_q = 16'd4800;
		dly_goal = delay_of(3'd0, 17'd32768);
		fb_goal = feedback_of(3'd0, 17'd32768);
		snap_to_goals();

		// Directed rows: reset values first, then extremes and clamping
		r.cmd = xydpr_pkg::CMD_TICK;
		r.x = 17'd0;
		r.y = 17'd0;
		r.known = 1;
		r.res = '{delay_time: xydpr_pkg::RESET_DELAY, feedback_amount: xydpr_pkg::RESET_FB,
			ramping: 1'b0};
		dir_rows.push_back(r);
		add_row(xydpr_pkg::CMD_SET, 17'd0, 17'd0);
		add_row(xydpr_pkg::CMD_TICK, 17'd0, 17'd0);
		add_row(xydpr_pkg::CMD_TICK, 17'h1FFFF, 17'h1FFFF);
		add_row(xydpr_pkg::CMD_SET, 17'd65536, 17'd65536);
		add_row(xydpr_pkg::CMD_TICK, 17'd0, 17'd0);
		add_row(xydpr_pkg::CMD_SET, 17'h1FFFF, 17'h1FFFF);
		add_row(xydpr_pkg::CMD_TICK, 17'd0, 17'd0);
		add_row(xydpr_pkg::CMD_SET, 17'd65537, 17'd0);
		add_row(xydpr_pkg::CMD_SET, 17'd32768, 17'd65535);
		add_row(xydpr_pkg::CMD_TICK, 17'd0, 17'd0);
		add_row(xydpr_pkg::CMD_SET, 17'd1, 17'd1);
		add_row(xydpr_pkg::CMD_TICK, 17'd0, 17'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_rows[i]) begin
			it.command = dir_rows[i].cmd;
			it.x_pos = dir_rows[i].x;
			it.y_pos = dir_rows[i].y;
			send_item(it, dir_rows[i].known, dir_rows[i].res);
		end
		drain();

		// Short ramps walked to their end, then zero length and smoothing off
		write_reg(xydpr_pkg::CFG_STEPS, 16'd3);
		write_reg(xydpr_pkg::CFG_PRESET, 16'd7);
		for (int i = 0; i < 12; i++) begin
			it.command = (i % 4 == 0) ? xydpr_pkg::CMD_SET : xydpr_pkg::CMD_TICK;
			it.x_pos = (i < 6) ? 17'd65536 : 17'd0;
			it.y_pos = (i < 6) ? 17'd0 : 17'd65536;
			send_item(it, 0, '0);
		end
		drain();
		write_reg(xydpr_pkg::CFG_STEPS, 16'd0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		send_item('{command: xydpr_pkg::CMD_SET, x_pos: 17'd50000, y_pos: 17'd20000}, 0, '0);
		send_item('{command: xydpr_pkg::CMD_TICK, x_pos: 17'd0, y_pos: 17'd0}, 0, '0);
		drain();
		write_reg(xydpr_pkg::CFG_SMOOTHING, 16'd0);
		write_reg(xydpr_pkg::CFG_STEPS, 16'hFFFF);
		send_item('{command: xydpr_pkg::CMD_SET, x_pos: 17'd10000, y_pos: 17'd60000}, 0, '0);
		send_item('{command: xydpr_pkg::CMD_TICK, x_pos: 17'd0, y_pos: 17'd0}, 0, '0);
		drain();

		// Random phases under changing settings
		sent = 0;
		for (int ph = 0; sent < 1150; ph++) begin
			write_reg(xydpr_pkg::CFG_PRESET, 16'($urandom));
			write_reg(xydpr_pkg::CFG_SMOOTHING,
				($urandom_range(4) == 0) ? 16'hFFFE : 16'hFFFF);
			case ($urandom_range(9))
				0: write_reg(xydpr_pkg::CFG_STEPS, 16'd0);
				1: write_reg(xydpr_pkg::CFG_STEPS, 16'hFFFF);
				2: write_reg(xydpr_pkg::CFG_STEPS, 16'd1);
				default: write_reg(xydpr_pkg::CFG_STEPS, 16'($urandom_range(2, 24)));
			endcase
			write_reg(CFG_UNUSED, 16'($urandom));
			calm = (ph == 3);
			if (ph == 5) hold_req = 1;
			phase_items = $urandom_range(20, 60);
			for (int i = 0; i < phase_items; i++) begin
				send_item(random_item(75), 0, '0);
				sent++;
			end
			drain();
		end
		calm = 0;

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			n_fail++;
		end
		if (n_fail == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
